// ----- design/quicksort_lomuto_engine_top_defines.svh -----
// Assertion helpers used by the asserting engine top module.
`ifndef QUICKSORT_LOMUTO_ENGINE_TOP_DEFINES_SVH
`define QUICKSORT_LOMUTO_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define QSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quicksort engine: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define QSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quicksort engine: next-cycle check failed");

`endif

// ----- design/qsl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qsl_pkg;

    localparam int unsigned IN_VALUE_W  = 32;
    localparam int unsigned OUT_VALUE_W = 32;
    localparam int unsigned WIDE_W      = 64;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] elem_value;
        logic                  elem_last;
    } qsl_item_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] sorted_value;
        logic                   sorted_last;
    } qsl_result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qsl_stack_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qsl_stack_stat_t;

endpackage

`default_nettype wire

// ----- design/qsl_elem_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qsl_elem_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/qsl_range_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qsl_range_stack
    import qsl_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6,
    parameter int unsigned PTR_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire qsl_stack_ctrl_t  ctrl,
    input  wire logic [IDX_W-1:0] push_lo,
    input  wire logic [IDX_W-1:0] push_hi,
    output logic      [IDX_W-1:0] pop_lo,
    output logic      [IDX_W-1:0] pop_hi,
    output qsl_stack_stat_t       stat
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [2*IDX_W-1:0] mem [DEPTH];
    logic [2*IDX_W-1:0] rd_reg;
    logic [PTR_W-1:0]   sp_reg;
    logic [PTR_W-1:0]   sp_next;
    logic [PTR_W-1:0]   sp_dec;
    logic               do_push;

    assign stat.empty = (sp_reg == '0);
    assign stat.full  = (sp_reg == PTR_W'(DEPTH));
    assign sp_dec     = sp_reg - PTR_W'(1);
    assign do_push    = ctrl.push && !stat.full;

    always_comb
    begin
        sp_next = sp_reg;
        if (do_push)
        begin
            sp_next = sp_reg + PTR_W'(1);
        end
        else if (ctrl.pop && !stat.empty)
        begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[sp_reg[ADDR_W-1:0]] <= {push_lo, push_hi};
        end
        rd_reg <= mem[sp_dec[ADDR_W-1:0]];
    end

    assign pop_lo = rd_reg[2*IDX_W-1:IDX_W];
    assign pop_hi = rd_reg[IDX_W-1:0];

endmodule

`default_nettype wire

// ----- design/quicksort_lomuto_engine_top.sv -----
// Load: each start writes an element; the set closes on elem_last or when the store fills.
// Sort: each partition reads its pivot, scans and swaps the range, then places the pivot, all
// set by the single read and single write port of the element RAM.
// Emit: n consecutive result strobes once sorting ends; busy drops with the last.
// Reset: asynchronous, clears the sequencer, counts and stack pointer; RAM contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "quicksort_lomuto_engine_top_defines.svh"

module quicksort_lomuto_engine_top
    import qsl_pkg::*;
#(
    parameter int unsigned MAX_ELEMS  = 64,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire qsl_item_t   item,
    output logic             result_strobe,
    output qsl_result_t      result
);

    localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
    localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_POP      = 11'b000_0000_0010,
        ST_POP_WAIT = 11'b000_0000_0100,
        ST_PIVOT    = 11'b000_0000_1000,
        ST_SCAN     = 11'b000_0001_0000,
        ST_SWAP1    = 11'b000_0010_0000,
        ST_SWAP2    = 11'b000_0100_0000,
        ST_FIN1     = 11'b000_1000_0000,
        ST_FIN2     = 11'b001_0000_0000,
        ST_FIN3     = 11'b010_0000_0000,
        ST_EMIT     = 11'b100_0000_0000
    } qsl_state_t;

    qsl_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      emit_reg, emit_next;
    logic [ELEM_WIDTH-1:0] pivot_reg, pivot_next;
    logic [ELEM_WIDTH-1:0] elem_reg, elem_next;
    logic                  strobe_reg, strobe_next;
    logic                  last_reg, last_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    qsl_stack_ctrl_t       stk_ctrl;
    qsl_stack_stat_t       stk_stat;
    logic [IDX_W-1:0]      push_lo;
    logic [IDX_W-1:0]      push_hi;
    logic [IDX_W-1:0]      pop_lo;
    logic [IDX_W-1:0]      pop_hi;

    logic [WIDE_W-1:0]     in_wide;
    logic [WIDE_W-1:0]     out_wide;
    logic [CNT_W-1:0]      cnt_inc;
    logic [IDX_W-1:0]      scan_inc;
    logic [IDX_W:0]        front_ext;
    logic [IDX_W:0]        lo_ext;
    logic [IDX_W:0]        hi_ext;
    logic                  is_less;

    assign in_wide   = WIDE_W'(item.elem_value);
    assign out_wide  = WIDE_W'(ram_rdata);
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign scan_inc  = scan_reg + IDX_W'(1);
    assign front_ext = {1'b0, front_reg};
    assign lo_ext    = {1'b0, lo_reg};
    assign hi_ext    = {1'b0, hi_reg};
    assign is_less   = (ram_rdata < pivot_reg);

    qsl_elem_ram #(
        .DEPTH  (MAX_ELEMS),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (IDX_W)
    ) u_elem_ram (
        .clk       (clk),
        .we        (ram_we),
        .waddr     (ram_waddr),
        .wdata     (ram_wdata),
        .raddr     (ram_raddr),
        .rdata_reg (ram_rdata)
    );

    qsl_range_stack #(
        .DEPTH (MAX_ELEMS),
        .IDX_W (IDX_W),
        .PTR_W (CNT_W)
    ) u_range_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (stk_ctrl),
        .push_lo (push_lo),
        .push_hi (push_hi),
        .pop_lo  (pop_lo),
        .pop_hi  (pop_hi),
        .stat    (stk_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        scan_next   = scan_reg;
        front_next  = front_reg;
        emit_next   = emit_reg;
        pivot_next  = pivot_reg;
        elem_next   = elem_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = scan_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = scan_reg;
        stk_ctrl    = '0;
        push_lo     = '0;
        push_hi     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = count_reg[IDX_W-1:0];
                    ram_wdata = in_wide[ELEM_WIDTH-1:0];
                    if (item.elem_last || (cnt_inc == CNT_W'(MAX_ELEMS)))
                    begin
                        count_next = '0;
                        n_next     = cnt_inc;
                        if (cnt_inc == CNT_W'(1))
                        begin
                            emit_next  = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            stk_ctrl.push = 1'b1;
                            push_lo       = '0;
                            push_hi       = IDX_W'(cnt_inc - CNT_W'(1));
                            state_next    = ST_POP;
                        end
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
            end
            ST_POP:
            begin
                if (stk_stat.empty)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    stk_ctrl.pop = 1'b1;
                    state_next   = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                lo_next = pop_lo;
                hi_next = pop_hi;
                if ((pop_lo >= pop_hi) || (CNT_W'(pop_hi) >= n_reg))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    ram_raddr  = pop_hi;
                    scan_next  = pop_lo;
                    front_next = pop_lo;
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT:
            begin
                pivot_next = ram_rdata;
                ram_raddr  = scan_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_reg == hi_reg)
                begin
                    ram_raddr  = front_reg;
                    state_next = ST_FIN1;
                end
                else if (is_less && (front_reg != scan_reg))
                begin
                    elem_next  = ram_rdata;
                    ram_raddr  = front_reg;
                    state_next = ST_SWAP1;
                end
                else
                begin
                    if (is_less)
                    begin
                        front_next = front_reg + IDX_W'(1);
                    end
                    scan_next = scan_inc;
                    ram_raddr = scan_inc;
                end
            end
            ST_SWAP1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = scan_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_SWAP2;
            end
            ST_SWAP2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = front_reg;
                ram_wdata  = elem_reg;
                front_next = front_reg + IDX_W'(1);
                scan_next  = scan_inc;
                ram_raddr  = scan_inc;
                state_next = ST_SCAN;
            end
            ST_FIN1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                ram_we    = 1'b1;
                ram_waddr = front_reg;
                ram_wdata = pivot_reg;
                if ((front_ext + (IDX_W+1)'(1)) < hi_ext)
                begin
                    stk_ctrl.push = 1'b1;
                    push_lo       = front_reg + IDX_W'(1);
                    push_hi       = hi_reg;
                end
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (front_ext > (lo_ext + (IDX_W+1)'(1)))
                begin
                    stk_ctrl.push = 1'b1;
                    push_lo       = lo_reg;
                    push_hi       = front_reg - IDX_W'(1);
                end
                state_next = ST_POP;
            end
            ST_EMIT:
            begin
                ram_raddr   = emit_reg;
                strobe_next = 1'b1;
                last_next   = (CNT_W'(emit_reg) == (n_reg - CNT_W'(1)));
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next = emit_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        scan_reg  <= scan_next;
        front_reg <= front_next;
        emit_reg  <= emit_next;
        pivot_reg <= pivot_next;
        elem_reg  <= elem_next;
        last_reg  <= last_next;
    end

    assign busy                = (state_reg != ST_IDLE);
    assign result_strobe       = strobe_reg;
    assign result.sorted_value = out_wide[OUT_VALUE_W-1:0];
    assign result.sorted_last  = last_reg;

    `QSL_ASSERT_NOW(a_front_not_past_scan, clk, rst_n, (state_reg == ST_SCAN), (front_reg <= scan_reg))
    `QSL_ASSERT_NOW(a_busy_drop_on_last, clk, rst_n, $fell(busy), (result_strobe && result.sorted_last))
    `QSL_ASSERT_NEXT(a_last_ends_burst, clk, rst_n, (result_strobe && result.sorted_last), !result_strobe)
    `QSL_ASSERT_NOW(a_no_push_and_pop, clk, rst_n, stk_ctrl.push, !stk_ctrl.pop)

endmodule

`default_nettype wire

// ----- tb/quicksort_lomuto_engine_top_tb.sv -----
`timescale 1ns / 1ps

module quicksort_lomuto_engine_top_tb;
    import qsl_pkg::*;

    localparam int unsigned MAX_ELEMS   = 64;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_WAIT  = 16;

    class sort_scoreboard;
        logic [IN_VALUE_W-1:0] open_set[$];
        qsl_result_t           sorted_due[$];
        int                    errors;

        function new();
            errors = 0;
        endfunction

        function void lomuto_sort_set();
            int                    lo_stack[$];
            int                    hi_stack[$];
            int                    lo;
            int                    hi;
            int                    front;
            int                    count;
            logic [IN_VALUE_W-1:0] pivot;
            logic [IN_VALUE_W-1:0] held;
            qsl_result_t           beat;
            count = open_set.size();
            if (count > 1)
            begin
                lo_stack.push_back(0);
                hi_stack.push_back(count - 1);
            end
            while (lo_stack.size() > 0)
            begin
                lo = lo_stack.pop_back();
                hi = hi_stack.pop_back();
                if (lo >= hi)
                    continue;
                pivot = open_set[hi];
                front = lo;
                for (int scan = lo; scan < hi; scan++)
                begin
                    if (open_set[scan] < pivot)
                    begin
                        held            = open_set[scan];
                        open_set[scan]  = open_set[front];
                        open_set[front] = held;
                        front++;
                    end
                end
                open_set[hi]    = open_set[front];
                open_set[front] = pivot;
                // right range first so the left one is popped first
                if (front + 1 < hi)
                begin
                    lo_stack.push_back(front + 1);
                    hi_stack.push_back(hi);
                end
                if (front > lo + 1)
                begin
                    lo_stack.push_back(lo);
                    hi_stack.push_back(front - 1);
                end
            end
            for (int k = 0; k < count; k++)
            begin
                beat.sorted_value = open_set[k][OUT_VALUE_W-1:0];
                beat.sorted_last  = (k == count - 1);
                sorted_due.push_back(beat);
            end
            open_set.delete();
        endfunction

        function void note_element(qsl_item_t it);
            open_set.push_back(it.elem_value);
            if (it.elem_last || open_set.size() == MAX_ELEMS)
                lomuto_sort_set();
        endfunction

        function void check_sorted(qsl_result_t got);
            qsl_result_t want;
            if (sorted_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, got value %h last %b",
                         $time, got.sorted_value, got.sorted_last);
                return;
            end
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value)
            begin
                errors++;
                $display("%0t: sorted_value mismatch: expected %h, got %h",
                         $time, want.sorted_value, got.sorted_value);
            end
            if (got.sorted_last !== want.sorted_last)
            begin
                errors++;
                $display("%0t: sorted_last mismatch: expected %b, got %b",
                         $time, want.sorted_last, got.sorted_last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    qsl_item_t   item;
    logic        result_strobe;
    qsl_result_t result;

    sort_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    sender_idle_pct;

    quicksort_lomuto_engine_top #(
        .MAX_ELEMS  (MAX_ELEMS),
        .ELEM_WIDTH (IN_VALUE_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_element(item);
            if (result_strobe)
                sb.check_sorted(result);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_element(input logic [IN_VALUE_W-1:0] value, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start          <= 1'b1;
        item.elem_value <= value;
        item.elem_last  <= last;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [IN_VALUE_W-1:0] pick_value(input int mode, input int idx);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(7);
            2: return 32'hFFFF_FFF0 + $urandom_range(15);
            3: return idx * 3 + $urandom_range(2);
            default: return 32'hFFFF_FFFF - idx * 5;
        endcase
    endfunction

    task automatic send_set(input int count, inout int sent);
        int mode;
        mode = $urandom_range(4);
        for (int k = 0; k < count; k++)
            send_element(pick_value(mode, k), k == count - 1);
        sent += count;
    endtask

    task automatic send_full_store(inout int sent);
        int mode;
        mode = $urandom_range(4);
        // set closes on the store filling, whatever the final last flag
        for (int k = 0; k < MAX_ELEMS; k++)
            send_element(pick_value(mode, k),
                         (k == MAX_ELEMS - 1) ? logic'($urandom_range(1)) : 1'b0);
        sent += MAX_ELEMS;
    endtask

    task automatic random_phase(input int unsigned idle_pct, input int target, input bit full);
        int sent;
        sent            = 0;
        sender_idle_pct = idle_pct;
        if (full)
            send_full_store(sent);
        while (sent < target)
        begin
            if ($urandom_range(9) == 0)
                send_set($urandom_range(9, 20), sent);
            else
                send_set($urandom_range(1, 8), sent);
        end
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        sender_idle_pct = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        send_element(32'hFFFF_FFFF, 1'b1);
        send_element(32'h0000_0000, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h0000_0000, 1'b1);
        send_element(32'd7, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd3, 1'b1);
        for (int k = 1; k <= 4; k++)
            send_element(k, k == 4);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h5555_5555, 1'b0);
        send_element(32'hAAAA_AAAA, 1'b0);
        send_element(32'h0000_0001, 1'b1);

        random_phase(24, 20, 1'b0);
        random_phase(70, 20, 1'b1);
        random_phase(0, 20, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        while (sb.sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.sorted_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
